// File: src/vns_pkg.sv
// shared constants, codes and types of the nearest seed table
`timescale 1ns / 1ps
`default_nettype none
package vns_pkg;

	// table geometry
	localparam int MAX_SEEDS  = 64;
	localparam int COORD_BITS = 12;

	localparam int IDX_W   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
	localparam int CNT_W   = $clog2(MAX_SEEDS + 1);
	localparam int DIST_W  = 2 * COORD_BITS + 1;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int COORD_MASK = (1 << COORD_BITS) - 1;

	// port field widths
	localparam int MODE_W   = 2;
	localparam int POS_W    = 12;
	localparam int COLOUR_W = 32;
	localparam int VEL_W    = 4;
	localparam int OIDX_W   = 6;
	localparam int ODIST_W  = 25;
	localparam int TOTAL_W  = 7;
	localparam int STATUS_W = 2;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FRAME_W    = 13;
	localparam int LIMIT_W    = 7;
	localparam int CMP_W      = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

	localparam logic [FRAME_W-1:0] FRAME_W_RST = FRAME_W'(640);
	localparam logic [FRAME_W-1:0] FRAME_H_RST = FRAME_W'(480);
	localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(64);

	localparam logic signed [VEL_W-1:0] VEL_MIN = 4'sb1000;
	localparam logic signed [VEL_W-1:0] VEL_MAX = 4'sb0111;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_SEED_LIMIT   = 2'd2
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR    = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_CLASSIFY = 2'd2,
		MODE_MOVE     = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_NOSEEDS = 2'd2
	} status_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [COLOUR_W-1:0]        colour;
		logic signed [VEL_W-1:0]    vx;
		logic signed [VEL_W-1:0]    vy;
		logic [COORD_BITS-1:0]      x;
		logic [COORD_BITS-1:0]      y;
	} seed_t;

	// valid flag and index of an entry read back from memory
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} probe_t;

	// running nearest seed
	typedef struct packed {
		logic [COLOUR_W-1:0] colour;
		logic [IDX_W-1:0]    idx;
		logic [DIST_W-1:0]   sqd;
	} best_t;

endpackage
`default_nettype wire

// File: src/vns_if.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps
`default_nettype none
interface vns_req_if import vns_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic [POS_W-1:0]           pos_x;
	logic [POS_W-1:0]           pos_y;
	logic [COLOUR_W-1:0]        seed_colour;
	logic signed [VEL_W-1:0]    step_x;
	logic signed [VEL_W-1:0]    step_y;

	modport source (output valid, mode, pos_x, pos_y, seed_colour, step_x, step_y,
		input ready);
	modport sink (input valid, mode, pos_x, pos_y, seed_colour, step_x, step_y,
		output ready);
endinterface

interface vns_rsp_if import vns_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COLOUR_W-1:0]   pixel_colour;
	logic [OIDX_W-1:0]     nearest_index;
	logic [ODIST_W-1:0]    nearest_distance;
	logic [TOTAL_W-1:0]    seed_total;
	logic [STATUS_W-1:0]   status;

	modport source (output valid, pixel_colour, nearest_index, nearest_distance,
		seed_total, status, input ready);
	modport sink (input valid, pixel_colour, nearest_index, nearest_distance,
		seed_total, status, output ready);
endinterface
`default_nettype wire

// File: src/vns_ram.sv
// generic simple dual port ram, registered read
`timescale 1ns / 1ps
`default_nettype none
module vns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/vns_move.sv
// one seed step with bounce on both axes
`timescale 1ns / 1ps
`default_nettype none
module vns_move import vns_pkg::*; (
	input  wire seed_t              cur,
	input  wire logic [FRAME_W-1:0] frame_w,
	input  wire logic [FRAME_W-1:0] frame_h,
	output seed_t                   nxt
);
	localparam int NXT_W = ((COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W) + 2;

	logic signed [NXT_W-1:0] sum_x, sum_y;
	logic                    hit_x, hit_y;

	always_comb begin
		sum_x = $signed(NXT_W'(cur.x)) + NXT_W'(cur.vx);
		sum_y = $signed(NXT_W'(cur.y)) + NXT_W'(cur.vy);
		// leaving below zero, past the frame or past the coordinate range
		hit_x = sum_x[NXT_W-1] || ($unsigned(sum_x) >= NXT_W'(frame_w))
			|| ($unsigned(sum_x) > NXT_W'(COORD_MASK));
		hit_y = sum_y[NXT_W-1] || ($unsigned(sum_y) >= NXT_W'(frame_h))
			|| ($unsigned(sum_y) > NXT_W'(COORD_MASK));

		nxt        = cur;
		if (hit_x) begin
			nxt.vx = (cur.vx == VEL_MIN) ? VEL_MAX : -cur.vx;
		end else begin
			nxt.x  = COORD_BITS'(sum_x);
		end
		if (hit_y) begin
			nxt.vy = (cur.vy == VEL_MIN) ? VEL_MAX : -cur.vy;
		end else begin
			nxt.y  = COORD_BITS'(sum_y);
		end
	end
endmodule
`default_nettype wire

// File: src/vns_dist.sv
// squared distance pipe and running nearest seed
`timescale 1ns / 1ps
`default_nettype none
module vns_dist import vns_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire probe_t                probe,
	input  wire seed_t                 entry,
	input  wire logic [COORD_BITS-1:0] px,
	input  wire logic [COORD_BITS-1:0] py,
	output logic                       busy,
	output best_t                      best
);
	logic [COORD_BITS-1:0] dx, dy;
	logic                  valid_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [COLOUR_W-1:0]   colour_s2;
	logic [SQ_W-1:0]       sqx_s2, sqy_s2;
	logic [DIST_W-1:0]     sum_sq;
	best_t                 best_q;

	always_comb begin
		dx = (px > entry.x) ? (px - entry.x) : (entry.x - px);
		dy = (py > entry.y) ? (py - entry.y) : (entry.y - py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= probe.valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2    <= probe.idx;
		colour_s2 <= entry.colour;
		sqx_s2    <= SQ_W'(dx) * SQ_W'(dx);
		sqy_s2    <= SQ_W'(dy) * SQ_W'(dy);
	end

	assign sum_sq = DIST_W'(sqx_s2) + DIST_W'(sqy_s2);

	// strict less-than keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (valid_s2 && ((idx_s2 == '0) || (sum_sq < best_q.sqd))) begin
			best_q.sqd    <= sum_sq;
			best_q.idx    <= idx_s2;
			best_q.colour <= colour_s2;
		end
	end

	assign busy = valid_s2;
	assign best = best_q;
endmodule
`default_nettype wire

// File: src/voronoi_nearest_seed_table.sv
// top level of the nearest seed table
`timescale 1ns / 1ps
`default_nettype none
// nearest seed table
// items arrive on req (valid/ready), one result per item leaves on rsp.
// a transfer happens when valid and ready are both high at a rising edge.
// configuration: cfg_we with cfg_index and cfg_data writes frame width (0),
// frame height (1) and seed limit (2); write only while the block is idle.
// seeds live in one 64-bit wide memory, one entry per seed, read one per cycle.
// clear, add and an empty table go straight to the done state, which loads
// the result into the output register. classify walks all N stored seeds,
// one memory read per cycle, through a two-stage distance pipe. move reads,
// steps and writes back one seed per cycle.
// one item is in work at a time; req.ready is high only while idle, which
// starts at the edge that loads the result into the output register.
// the result sits in an output register, so the next item is taken while the
// receiver stalls; a finished result waits in the done state until the
// output register frees up.
// reset clears the seed count and restores the frame and limit registers;
// memory contents are undefined until written and need no clearing pass.
module voronoi_nearest_seed_table import vns_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	vns_req_if.sink                    req,
	vns_rsp_if.source                  rsp
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	// configuration
	logic [FRAME_W-1:0] frame_w_q, frame_h_q;
	logic [LIMIT_W-1:0] limit_q;

	// item control
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rd_q;
	logic                  cls_q;
	logic                  mv_q;
	status_t               status_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic                  s1_valid_q;
	logic [IDX_W-1:0]      idx_s1;

	// output register
	logic                  out_valid_q;
	logic [COLOUR_W-1:0]   out_colour_q;
	logic [OIDX_W-1:0]     out_idx_q;
	logic [ODIST_W-1:0]    out_dist_q;
	logic [TOTAL_W-1:0]    out_total_q;
	logic [STATUS_W-1:0]   out_status_q;

	logic       accept, full, issue, done, out_free, dist_busy;
	seed_t      rd_entry, mv_entry, add_entry, wr_entry;
	logic       wr_en;
	logic [IDX_W-1:0] wr_addr;
	probe_t     probe;
	best_t      best;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	// the table holds at most the smaller of the limit register and its depth
	assign full = (CMP_W'(cnt_q) >= CMP_W'(MAX_SEEDS)) || (CMP_W'(cnt_q) >= CMP_W'(limit_q));

	assign issue = (state_q == ST_RUN) && (rd_q != cnt_q);
	assign done  = (state_q == ST_RUN) && !issue && !s1_valid_q && !dist_busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= FRAME_W_RST;
			frame_h_q <= FRAME_H_RST;
			limit_q   <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_w_q <= FRAME_W'(cfg_data);
				REG_FRAME_HEIGHT: frame_h_q <= FRAME_W'(cfg_data);
				REG_SEED_LIMIT:   limit_q   <= LIMIT_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// new entry from the item payload
	always_comb begin
		add_entry.colour = req.seed_colour;
		add_entry.vx     = req.step_x;
		add_entry.vy     = req.step_y;
		add_entry.x      = COORD_BITS'(req.pos_x);
		add_entry.y      = COORD_BITS'(req.pos_y);
	end

	// add writes at the transfer edge, move writes back the entry read last cycle
	always_comb begin
		if (state_q == ST_RUN) begin
			wr_en    = mv_q && s1_valid_q;
			wr_addr  = idx_s1;
			wr_entry = mv_entry;
		end else begin
			wr_en    = accept && (req.mode == MODE_ADD) && !full;
			wr_addr  = cnt_q[IDX_W-1:0];
			wr_entry = add_entry;
		end
	end

	vns_ram #(
		.WIDTH ($bits(seed_t)),
		.DEPTH (MAX_SEEDS)
	) u_seed_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	vns_move u_move (
		.cur     (rd_entry),
		.frame_w (frame_w_q),
		.frame_h (frame_h_q),
		.nxt     (mv_entry)
	);

	assign probe.valid = s1_valid_q && cls_q;
	assign probe.idx   = idx_s1;

	vns_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.probe  (probe),
		.entry  (rd_entry),
		.px     (px_q),
		.py     (py_q),
		.busy   (dist_busy),
		.best   (best)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rd_q       <= '0;
			cls_q      <= 1'b0;
			mv_q       <= 1'b0;
			status_q   <= STAT_OK;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cls_q    <= 1'b0;
						mv_q     <= 1'b0;
						status_q <= STAT_OK;
						state_q  <= ST_DONE;
						unique case (req.mode)
							MODE_CLEAR: begin
								cnt_q <= '0;
							end
							MODE_ADD: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							MODE_CLASSIFY, MODE_MOVE: begin
								if (cnt_q == '0) begin
									status_q <= STAT_NOSEEDS;
								end else begin
									cls_q   <= (req.mode == MODE_CLASSIFY);
									mv_q    <= (req.mode == MODE_MOVE);
									rd_q    <= '0;
									state_q <= ST_RUN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					if (done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pixel and index of the current read
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDX_W-1:0];
		if (accept) begin
			px_q <= COORD_BITS'(req.pos_x);
			py_q <= COORD_BITS'(req.pos_y);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_colour_q <= cls_q ? best.colour : '0;
			out_idx_q    <= cls_q ? OIDX_W'(best.idx) : '0;
			out_dist_q   <= cls_q ? ODIST_W'(best.sqd) : '0;
			out_total_q  <= TOTAL_W'(cnt_q);
			out_status_q <= status_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.pixel_colour     = out_colour_q;
	assign rsp.nearest_index    = out_idx_q;
	assign rsp.nearest_distance = out_dist_q;
	assign rsp.seed_total       = out_total_q;
	assign rsp.status           = out_status_q;
endmodule
`default_nettype wire
